[rtl/priority_queue_linear_scan_macros.svh]
// ----------------------------------------------------------------------------
// Priority queue assertion macros
// Concurrent assertion forms for the priority queue datapath.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH
`define PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH

// Checks that a condition holds whenever the trigger holds, outside reset.
`define PQLS_ASSERT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("priority queue check failed");

// Checks that a condition holds in the cycle after the trigger, outside reset.
`define PQLS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("priority queue check failed");

`endif

[rtl/pqls_pkg.sv]
// ----------------------------------------------------------------------------
// Priority queue package
// Shared constants, status codes and control structures.
// ----------------------------------------------------------------------------
package pqls_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int VAL_W     = 32;
  localparam int PRI_W     = 16;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } pqls_status_t;

  typedef struct packed {
    logic accept;
    logic dec;
    logic scan;
    logic scan_end;
    logic fetch;
    logic shift;
    logic sh_end;
    logic fin_load;
  } pqls_cmd_t;

  typedef struct packed {
    logic req_remove;
    logic empty;
    logic scan_last;
    logic best_is_head;
    logic sh_last;
    logic out_free;
  } pqls_stat_t;

endpackage

[rtl/pqls_ctrl.sv]
// ----------------------------------------------------------------------------
// Priority queue controller
// Sequences decode, scan, fetch, shift and result hand-off; inserts and refused requests go from decode to hand-off.
// ----------------------------------------------------------------------------
module pqls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  pqls_pkg::pqls_stat_t stat,
  output pqls_pkg::pqls_cmd_t  cmd
);
  import pqls_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DEC      = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_SCAN_END = 8'b0000_1000,
    S_FETCH    = 8'b0001_0000,
    S_SHIFT    = 8'b0010_0000,
    S_SH_END   = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (stat.req_remove && !stat.empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_nxt    = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.best_is_head) begin
          state_nxt = S_SH_END;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.sh_last) begin
          state_nxt = S_SH_END;
        end
      end
      S_SH_END: begin
        cmd.sh_end = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/pqls_datapath.sv]
// ----------------------------------------------------------------------------
// Priority queue datapath
// Entry store, front and rear pointers, maximum scan, shift and result register.
// ----------------------------------------------------------------------------
`include "priority_queue_linear_scan_macros.svh"

module pqls_datapath #(
  parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_req,
  input  logic signed [pqls_pkg::VAL_W-1:0] in_value,
  input  logic signed [pqls_pkg::PRI_W-1:0] in_prio,
  input  pqls_pkg::pqls_cmd_t               cmd,
  output pqls_pkg::pqls_stat_t              stat,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [1:0]                        out_status,
  output logic signed [pqls_pkg::VAL_W-1:0] out_value
);
  import pqls_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic signed [VAL_W-1:0] val_mem [DEPTH];
  logic signed [PRI_W-1:0] pri_mem [DEPTH];

  logic                    req_remove_r;
  logic signed [VAL_W-1:0] req_value_r;
  logic signed [PRI_W-1:0] req_prio_r;

  logic [IW-1:0] head_r;
  logic [IW-1:0] tail_r;
  logic          empty_r;

  logic [IW-1:0]           scan_idx_r;
  logic                    cmp_vld_r;
  logic [IW-1:0]           cmp_idx_r;
  logic [IW-1:0]           best_idx_r;
  logic signed [PRI_W-1:0] best_pri_r;

  logic [IW-1:0] sh_idx_r;
  logic          wr_pend_r;
  logic [IW-1:0] wr_addr_r;
  logic          fetch_vld_r;

  logic signed [VAL_W-1:0] rd_val_r;
  logic signed [PRI_W-1:0] rd_pri_r;

  pqls_status_t            res_status_r;
  logic signed [VAL_W-1:0] res_value_r;

  logic                    out_vld_r;
  pqls_status_t            out_status_r;
  logic signed [VAL_W-1:0] out_value_r;

  logic                    full;
  logic                    ins_we;
  logic [IW-1:0]           ins_addr;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wval;
  logic signed [PRI_W-1:0] mem_wpri;
  logic [IW-1:0]           rd_addr;
  logic                    out_free;

  assign full     = (tail_r == IW'(DEPTH - 1));
  assign ins_we   = cmd.dec && (req_remove_r == REQ_INSERT) && (empty_r || !full);
  assign ins_addr = empty_r ? '0 : tail_r + IW'(1);

  assign mem_we    = ins_we || wr_pend_r;
  assign mem_waddr = wr_pend_r ? wr_addr_r : ins_addr;
  assign mem_wval  = wr_pend_r ? rd_val_r : req_value_r;
  assign mem_wpri  = wr_pend_r ? rd_pri_r : req_prio_r;

  always_comb begin
    if (cmd.scan) begin
      rd_addr = scan_idx_r;
    end else if (cmd.fetch) begin
      rd_addr = best_idx_r;
    end else begin
      rd_addr = sh_idx_r - IW'(1);
    end
  end

  assign out_free = !out_vld_r || out_tready;

  assign stat.req_remove   = (req_remove_r == REQ_REMOVE);
  assign stat.empty        = empty_r;
  assign stat.scan_last    = (scan_idx_r == tail_r);
  assign stat.best_is_head = (best_idx_r == head_r);
  assign stat.sh_last      = ((sh_idx_r - IW'(1)) == head_r);
  assign stat.out_free     = out_free;

  assign out_tvalid = out_vld_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[mem_waddr] <= mem_wval;
      pri_mem[mem_waddr] <= mem_wpri;
    end
    rd_val_r <= val_mem[rd_addr];
    rd_pri_r <= pri_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_remove_r <= in_req;
      req_value_r  <= in_value;
      req_prio_r   <= in_prio;
    end
    if (cmd.dec) begin
      scan_idx_r <= head_r;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (cmp_vld_r && ((cmp_idx_r == head_r) || (rd_pri_r > best_pri_r))) begin
      best_idx_r <= cmp_idx_r;
      best_pri_r <= rd_pri_r;
    end
    if (cmd.fetch) begin
      sh_idx_r <= best_idx_r;
    end else if (cmd.shift) begin
      sh_idx_r <= sh_idx_r - IW'(1);
    end
    wr_addr_r <= sh_idx_r;
    if (cmd.dec) begin
      res_value_r <= '0;
      if (req_remove_r == REQ_REMOVE) begin
        res_status_r <= empty_r ? ST_EMPTY : ST_DONE;
      end else begin
        res_status_r <= (!empty_r && full) ? ST_FULL : ST_DONE;
      end
    end else if (fetch_vld_r) begin
      res_value_r <= rd_val_r;
    end
    if (cmd.fin_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      cmp_vld_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      fetch_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      cmp_vld_r   <= cmd.scan;
      wr_pend_r   <= cmd.shift;
      fetch_vld_r <= cmd.fetch;
      if (ins_we) begin
        if (empty_r) begin
          head_r  <= '0;
          tail_r  <= '0;
          empty_r <= 1'b0;
        end else begin
          tail_r <= tail_r + IW'(1);
        end
      end else if (cmd.sh_end) begin
        if (head_r == tail_r) begin
          head_r  <= '0;
          tail_r  <= '0;
          empty_r <= 1'b1;
        end else begin
          head_r <= head_r + IW'(1);
        end
      end
      if (cmd.fin_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  `PQLS_ASSERT(a_head_le_tail, !empty_r, head_r <= tail_r)
  `PQLS_ASSERT(a_empty_at_zero, empty_r, (head_r == '0) && (tail_r == '0))
  `PQLS_ASSERT(a_no_write_clash, wr_pend_r, !ins_we)
  `PQLS_ASSERT(a_load_when_free, cmd.fin_load, out_free)
  `PQLS_ASSERT_NEXT(a_scan_not_empty, cmd.scan, !empty_r)
  `PQLS_ASSERT_NEXT(a_scan_end_fetch, cmd.scan_end, cmd.fetch)

endmodule

[rtl/priority_queue_linear_scan.sv]
// ----------------------------------------------------------------------------
// Linear-scan priority queue
// Unsorted array queue with insert at the rear and remove of the highest
// priority entry.
// ----------------------------------------------------------------------------
// An insert or a refused request goes from decode straight to the finish
// state. A remove of a non-empty queue scans the stored entries for the
// maximum, then fetches the winner and shifts the entries ahead of it back; both
// the maximum scan and the shift go through the entry store one read per cycle.
// One request is handled at a time, and the next one is taken while the result
// waits in the output register. Inserts are refused once the rear has reached
// the last slot, until the queue empties. On equal priorities the entry nearest
// the front is removed first.
module priority_queue_linear_scan #(
  parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // item_value[31:0], item_priority[47:32]
  input  logic [0:0]  in_tuser,  // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // removed_value[31:0]
  output logic [1:0]  out_tuser  // status[1:0]
);
  import pqls_pkg::*;

  pqls_cmd_t cmd;
  pqls_stat_t stat;
  logic signed [VAL_W-1:0] out_value;

  pqls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pqls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_tuser[0]),
    .in_value   (in_tdata[31:0]),
    .in_prio    (in_tdata[47:32]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (out_tuser),
    .out_value  (out_value)
  );

  assign out_tdata = out_value;

endmodule

[tb/sv/priority_queue_linear_scan_test.sv]
// ----------------------------------------------------------------------------
// Linear-scan priority queue testbench
// Sends insert and remove requests over the input stream and checks every
// status and removed value against a behavioral copy of the queue. A
// directed opening covers the empty, full, tie and extreme-priority cases;
// random insert and remove bursts follow, with idle cycles on both streams
// and one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module priority_queue_linear_scan_test;
  import pqls_pkg::*;

  localparam int QDEPTH       = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1725;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;
  localparam int STALL_AFTER  = 100;

  typedef struct {
    logic              req;
    logic [VAL_W-1:0]  value;
    logic [PRI_W-1:0]  prio;
  } pq_request_t;

  typedef struct {
    pqls_status_t      status;
    logic [VAL_W-1:0]  value;
  } pq_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;   // item_value[31:0], item_priority[47:32]
  logic [0:0]        in_tuser = '0;   // req_type[0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;       // removed_value[31:0]
  logic [1:0]        out_tuser;       // status[1:0]

  pq_request_t       req_backlog[$];
  pq_reply_t         awaited_replies[$];

  logic [VAL_W-1:0]  slot_value [QDEPTH];
  logic [PRI_W-1:0]  slot_prio  [QDEPTH];
  int                front_slot = 0;
  int                rear_slot = 0;
  bit                queue_empty = 1'b1;

  int                sent_cnt = 0;
  int                total_items = 0;
  int                errors = 0;
  int                cycle_cnt = 0;
  int                stall_left = 0;
  bit                stall_done = 1'b0;

  priority_queue_linear_scan uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic pq_reply_t serve_request(pq_request_t r);
    pq_reply_t  rep;
    int         best;
    rep.status = ST_DONE;
    rep.value  = '0;
    if (r.req == REQ_INSERT) begin
      if (queue_empty) begin
        front_slot = 0;
        rear_slot  = 0;
        slot_value[0] = r.value;
        slot_prio[0]  = r.prio;
        queue_empty = 1'b0;
      end else if (rear_slot >= QDEPTH - 1) begin
        rep.status = ST_FULL;
      end else begin
        rear_slot++;
        slot_value[rear_slot] = r.value;
        slot_prio[rear_slot]  = r.prio;
      end
    end else if (queue_empty) begin
      rep.status = ST_EMPTY;
    end else if (front_slot >= rear_slot) begin
      rep.value  = slot_value[front_slot];
      front_slot = 0;
      rear_slot  = 0;
      queue_empty = 1'b1;
    end else begin
      best = front_slot;
      for (int i = front_slot + 1; i <= rear_slot; i++) begin
        if ($signed(slot_prio[i]) > $signed(slot_prio[best])) best = i;
      end
      rep.value = slot_value[best];
      for (int i = best; i > front_slot; i--) begin
        slot_value[i] = slot_value[i - 1];
        slot_prio[i]  = slot_prio[i - 1];
      end
      front_slot++;
    end
    return rep;
  endfunction

  function automatic int sender_idle_pct();
    if (sent_cnt < total_items / 3) return 21;
    if (sent_cnt < 2 * total_items / 3) return 48;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_cnt < total_items / 3) return 48;
    if (sent_cnt < 2 * total_items / 3) return 21;
    return 0;
  endfunction

  task automatic queue_request(logic req, logic [VAL_W-1:0] value, logic [PRI_W-1:0] prio);
    pq_request_t r;
    r.req   = req;
    r.value = value;
    r.prio  = prio;
    req_backlog.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        pq_request_t r;
        r.req   = in_tuser[0];
        r.value = in_tdata[31:0];
        r.prio  = in_tdata[47:32];
        awaited_replies.push_back(serve_request(r));
        sent_cnt <= sent_cnt + 1;
      end
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {req_backlog[0].prio, req_backlog[0].value};
        in_tuser  <= req_backlog[0].req;
        void'(req_backlog.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && sent_cnt >= STALL_AFTER) begin
      out_tready <= 1'b0;
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        pq_reply_t exp;
        exp = awaited_replies.pop_front();
        if (out_tuser !== exp.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp.status, out_tuser);
          errors++;
        end
        if (out_tdata !== exp.value) begin
          $display("%0t: removed value mismatch, expected %h actual %h",
                   $time, exp.value, out_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int          n_ins;
    int          n_rem;
    bit          tie_mode;
    logic [15:0] p;

    queue_request(REQ_REMOVE, 32'h1234_5678, 16'h1234);
    queue_request(REQ_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
    queue_request(REQ_INSERT, 32'h8000_0000, 16'h8000);
    queue_request(REQ_INSERT, 32'h0000_0000, 16'h0000);
    queue_request(REQ_INSERT, 32'hFFFF_FFFF, 16'h7FFF);
    queue_request(REQ_INSERT, 32'h0000_0005, 16'hFFFF);
    queue_request(REQ_INSERT, 32'h0000_0006, 16'h0001);
    queue_request(REQ_INSERT, 32'h0000_0007, 16'h8000);
    queue_request(REQ_INSERT, 32'h0000_0008, 16'h0000);
    queue_request(REQ_INSERT, 32'h0000_0009, 16'h7FFF);
    queue_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    queue_request(REQ_REMOVE, 32'h0000_0000, 16'h0000);
    queue_request(REQ_INSERT, 32'h0000_000A, 16'h7FFF);
    repeat (6) queue_request(REQ_REMOVE, $urandom, 16'($urandom));
    queue_request(REQ_REMOVE, 32'h0, 16'h0);
    queue_request(REQ_INSERT, 32'hAAAA_AAAA, 16'h5555);
    queue_request(REQ_INSERT, 32'h5555_5555, 16'hAAAA);
    queue_request(REQ_REMOVE, 32'h0, 16'h0);
    queue_request(REQ_REMOVE, 32'h0, 16'h0);
    queue_request(REQ_REMOVE, 32'h0, 16'h0);

    while (req_backlog.size() < RANDOM_ITEMS + 25) begin
      n_ins    = $urandom_range(1, 10);
      n_rem    = $urandom_range(1, 10);
      tie_mode = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < n_ins; i++) begin
        p = tie_mode ? 16'($signed($urandom_range(0, 3)) - 1) : 16'($urandom);
        queue_request(REQ_INSERT, $urandom, p);
      end
      for (int i = 0; i < n_rem; i++) queue_request(REQ_REMOVE, $urandom, 16'($urandom));
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6)) queue_request(1'($urandom), $urandom, 16'($urandom));
      end
    end
    total_items = req_backlog.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < total_items) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
